// ===== rtl/twm_pkg.sv =====
// twm_pkg: shared constants, types and opcodes of the topic wildcard matcher
// used by twm_matcher, twm_result_q, the top level and the checker, depends on nothing

package twm_pkg;

    // filter store geometry
    localparam int MAX_FILTER_LEN = 64;
    localparam int ADDR_W         = $clog2(MAX_FILTER_LEN);
    localparam int LEN_W          = $clog2(MAX_FILTER_LEN + 1);
    localparam int CHAR_W         = 8;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TOPIC = 1'b1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [LEN_W-1:0]  t_pos;
    typedef logic [ADDR_W-1:0] t_addr;

    // filter store write port
    typedef struct packed {
        logic  en;
        t_addr addr;
        t_char data;
    } t_ram_wr;

    // filter store read addresses
    typedef struct packed {
        t_addr addr0;
        t_addr addr1;
    } t_ram_rd;

    typedef struct packed {
        logic matched;
        logic filter_overflow;
    } t_res_data;

    typedef struct packed {
        logic      valid;
        t_res_data data;
    } t_result;

endpackage

// ===== rtl/twm_if.sv =====
// twm_if: request and result channel interfaces of the topic wildcard matcher
// valid/ready handshake with payload, no dependencies

interface twm_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output opcode, output character, output last, input ready);
    modport sink   (input valid, input opcode, input character, input last, output ready);
    modport monitor(input valid, input opcode, input character, input last, input ready);
endinterface

interface twm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic filter_overflow;

    modport source (output valid, output matched, output filter_overflow, input ready);
    modport sink   (input valid, input matched, input filter_overflow, output ready);
    modport monitor(input valid, input matched, input filter_overflow, input ready);
endinterface

// ===== rtl/twm_filter_ram.sv =====
// twm_filter_ram: generic one-write two-read synchronous ram, registered reads
// standalone, no package dependency

module twm_filter_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr0,
    input  logic [AW-1:0]    i_rd_addr1,
    output logic [WIDTH-1:0] o_rd_data0,
    output logic [WIDTH-1:0] o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

// ===== rtl/twm_matcher.sv =====
// twm_matcher: filter loader, per-character match step and end-of-topic stage
// uses twm_pkg, drives the filter store ports and pushes results

module twm_matcher
    import twm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic    i_opcode,
    input  t_char   i_character,
    input  logic    i_last,
    input  t_char   i_rd0,
    input  t_char   i_rd1,
    output t_ram_wr o_wr,
    output t_ram_rd o_rd,
    output t_result o_result
);

    typedef logic [1:0] t_verdict;

    localparam t_verdict V_RUNNING = 2'd0;
    localparam t_verdict V_MATCHED = 2'd1;
    localparam t_verdict V_FAILED  = 2'd2;

    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_HASH  = 8'h23;
    localparam t_char CH_SLASH = 8'h2F;

    typedef struct packed {
        t_pos     pos;
        t_verdict ver;
    } t_step;

    // one topic character against filter byte f at pos
    function automatic t_step take_char(
        input t_verdict ver,
        input t_pos     pos,
        input t_pos     len,
        input t_char    f,
        input t_char    c,
        input t_char    nxt
    );
        t_step s;
        s.pos = pos;
        s.ver = ver;
        if (ver == V_RUNNING) begin
            if (pos >= len) begin
                s.ver = V_FAILED;
            end else if (f == CH_HASH) begin
                s.ver = V_MATCHED;
            end else if (f == c) begin
                s.pos = pos + t_pos'(1);
            end else if (f == CH_PLUS) begin
                if (nxt == CH_SLASH) begin
                    s.pos = pos + t_pos'(1);
                end
            end else begin
                s.ver = V_FAILED;
            end
        end
        return s;
    endfunction

    // topic and filter state
    t_pos     r_pos, n_pos;
    t_verdict r_verdict, n_verdict;
    t_char    r_pend_char, n_pend_char;
    logic     r_pend_valid, n_pend_valid;
    t_pos     r_len, n_len;
    logic     r_load_active, n_load_active;
    logic     r_ovf, n_ovf;

    // end-of-topic stage
    logic     r_tail_valid, n_tail_valid;
    t_pos     r_tail_pos, n_tail_pos;
    t_verdict r_tail_ver, n_tail_ver;
    t_char    r_tail_char, n_tail_char;
    logic     r_tail_ovf, n_tail_ovf;

    t_step    step_a;
    t_step    step_b;
    t_pos     len_base;
    logic     ovf_base;
    logic     capture;
    t_char    f_end;
    t_verdict fin;

    // step on the held character, lookahead is the arriving one
    always_comb begin
        step_a = take_char(r_verdict, r_pos, r_len, i_rd0, r_pend_char, i_character);
        if (!r_pend_valid) begin
            step_a.pos = r_pos;
            step_a.ver = r_verdict;
        end
    end

    assign capture = i_fire && (i_opcode == OP_TOPIC) && i_last;

    always_comb begin
        n_pos         = r_pos;
        n_verdict     = r_verdict;
        n_pend_char   = r_pend_char;
        n_pend_valid  = r_pend_valid;
        n_len         = r_len;
        n_load_active = r_load_active;
        n_ovf         = r_ovf;
        n_tail_valid  = 1'b0;
        n_tail_pos    = r_tail_pos;
        n_tail_ver    = r_tail_ver;
        n_tail_char   = r_tail_char;
        n_tail_ovf    = r_tail_ovf;
        o_wr          = '0;
        len_base      = r_load_active ? r_len : '0;
        ovf_base      = r_load_active ? r_ovf : 1'b0;

        if (i_fire) begin
            if (i_opcode == OP_LOAD) begin
                n_pos        = '0;
                n_verdict    = V_RUNNING;
                n_pend_char  = '0;
                n_pend_valid = 1'b0;
                if (len_base < t_pos'(MAX_FILTER_LEN)) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = len_base[ADDR_W-1:0];
                    o_wr.data = i_character;
                    n_len     = len_base + t_pos'(1);
                    n_ovf     = ovf_base;
                end else begin
                    n_len = len_base;
                    n_ovf = 1'b1;
                end
                n_load_active = !i_last;
            end else begin
                n_load_active = 1'b0;
                if (!i_last) begin
                    n_pend_char  = i_character;
                    n_pend_valid = 1'b1;
                    n_pos        = step_a.pos;
                    n_verdict    = step_a.ver;
                end else begin
                    n_tail_valid = 1'b1;
                    n_tail_pos   = step_a.pos;
                    n_tail_ver   = step_a.ver;
                    n_tail_char  = i_character;
                    n_tail_ovf   = r_ovf;
                    n_pos        = '0;
                    n_verdict    = V_RUNNING;
                    n_pend_char  = '0;
                    n_pend_valid = 1'b0;
                end
            end
        end
    end

    // port 0 follows the next position, or the end stage's position on a last request
    always_comb begin
        o_rd.addr0 = capture ? step_a.pos[ADDR_W-1:0] : n_pos[ADDR_W-1:0];
        o_rd.addr1 = step_a.pos[ADDR_W-1:0] + t_addr'(1);
    end

    // end stage: final character with no lookahead, then the trailing check
    always_comb begin
        step_b = take_char(r_tail_ver, r_tail_pos, r_len, i_rd0, r_tail_char, '0);
        f_end  = (step_b.pos == r_tail_pos) ? i_rd0 : i_rd1;
        fin    = step_b.ver;
        if (step_b.ver == V_RUNNING) begin
            if ((step_b.pos < r_len) && (f_end != CH_PLUS)) begin
                fin = V_FAILED;
            end else begin
                fin = V_MATCHED;
            end
        end
        o_result.valid                = r_tail_valid;
        o_result.data.matched         = (fin == V_MATCHED);
        o_result.data.filter_overflow = r_tail_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_verdict     <= V_RUNNING;
            r_pend_valid  <= 1'b0;
            r_len         <= '0;
            r_load_active <= 1'b0;
            r_ovf         <= 1'b0;
            r_tail_valid  <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_verdict     <= n_verdict;
            r_pend_valid  <= n_pend_valid;
            r_len         <= n_len;
            r_load_active <= n_load_active;
            r_ovf         <= n_ovf;
            r_tail_valid  <= n_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_char <= n_pend_char;
        r_tail_pos  <= n_tail_pos;
        r_tail_ver  <= n_tail_ver;
        r_tail_char <= n_tail_char;
        r_tail_ovf  <= n_tail_ovf;
    end

endmodule

// ===== rtl/twm_result_q.sv =====
// twm_result_q: small result queue in front of the result channel
// uses twm_pkg and twm_res_if

module twm_result_q
    import twm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_push,
    twm_res_if.source o_res,
    output logic      o_room
);

    t_res_data           r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count, n_count;
    logic                pop;
    logic [Q_CNT_W:0]    fill;

    assign pop                   = o_res.valid && o_res.ready;
    assign o_res.valid           = (r_count != '0);
    assign o_res.matched         = r_q[r_rd_ptr].matched;
    assign o_res.filter_overflow = r_q[r_rd_ptr].filter_overflow;

    // an in-flight push counts against the room left
    assign fill   = {1'b0, r_count} + {{Q_CNT_W{1'b0}}, i_push.valid};
    assign o_room = (fill < (Q_CNT_W+1)'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = r_wr_ptr + Q_PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + Q_PTR_W'(1);
        end
        if (i_push.valid && !pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push.valid && pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

// ===== rtl/topic_wildcard_matcher.sv =====
// topic_wildcard_matcher: top level of the subscription filter / topic matcher
// uses twm_pkg, twm_if, twm_filter_ram, twm_matcher and twm_result_q
//
// usage
//   i_req carries one character per request: opcode load writes the next
//   filter byte into the filter store, opcode topic streams one byte of a
//   published topic; last marks the final byte of either
//   o_res carries one result per topic request with last set: matched and
//   filter_overflow (the filter was longer than the store and got truncated)
//   a request is accepted on every cycle with valid and ready high; the block
//   takes one request per cycle, loads and topics alike, while the queue has room
//   the result of a topic is registered in the end stage, then pushed into the
//   result queue, from which it shows on o_res
//   each topic byte is matched one request late, when its successor arrives,
//   so the filter byte at the current position is already waiting in the
//   registered read of the store; the end stage reads two neighboring bytes,
//   the second through store port 1
//   results wait in a four-entry queue; when o_res stalls and the queue plus
//   the result in flight fill it, i_req.ready drops until a result is taken
//   reset (synchronous, active low) empties the filter, the queue and the
//   topic in progress; the filter store itself is not cleared, no start-up
//   sweep is needed because only bytes below the filter length are used

module topic_wildcard_matcher
    import twm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    twm_req_if.sink  i_req,
    twm_res_if.source o_res
);

    logic    room;
    logic    fire;
    t_ram_wr wr;
    t_ram_rd rd;
    t_char   rd_data0;
    t_char   rd_data1;
    t_result result;

    // request ready depends only on queue room
    assign i_req.ready = room;
    assign fire        = i_req.valid && room;

    // filter store
    twm_filter_ram #(
        .DEPTH (MAX_FILTER_LEN),
        .WIDTH (CHAR_W)
    ) u_filter_ram (
        .i_clk      (i_clk),
        .i_wr_en    (wr.en),
        .i_wr_addr  (wr.addr),
        .i_wr_data  (wr.data),
        .i_rd_addr0 (rd.addr0),
        .i_rd_addr1 (rd.addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    // loader and match engine
    twm_matcher u_matcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_opcode    (i_req.opcode),
        .i_character (i_req.character),
        .i_last      (i_req.last),
        .i_rd0       (rd_data0),
        .i_rd1       (rd_data1),
        .o_wr        (wr),
        .o_rd        (rd),
        .o_result    (result)
    );

    // result queue toward the receiver
    twm_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result),
        .o_res   (o_res),
        .o_room  (room)
    );

endmodule

// ===== rtl/twm_checker.sv =====
// twm_checker: port-level assertions of the topic wildcard matcher
// uses twm_pkg, bound to topic_wildcard_matcher

module twm_checker
    import twm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_req_opcode,
    input logic i_req_last,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_matched,
    input logic i_res_filter_overflow
);

    logic last_topic_fire;

    assign last_topic_fire = i_req_valid && i_req_ready && (i_req_opcode == OP_TOPIC)
                             && i_req_last;

    // stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> ($stable(i_res_matched)
                                           && $stable(i_res_filter_overflow)))
        else $error("result payload changed while stalled");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered after reset");

    // a new result only follows the last request of a topic
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(last_topic_fire, 2))
        else $error("result without a finished topic");

endmodule

bind topic_wildcard_matcher twm_checker u_twm_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_req_opcode          (i_req.opcode),
    .i_req_last            (i_req.last),
    .i_res_valid           (o_res.valid),
    .i_res_ready           (o_res.ready),
    .i_res_matched         (o_res.matched),
    .i_res_filter_overflow (o_res.filter_overflow)
);

// ===== verif/tb_topic_wildcard_matcher.sv =====
`timescale 1ns / 1ps
// tb_topic_wildcard_matcher: self-checking testbench of the topic wildcard matcher
// depends on twm_pkg, twm_if (twm_req_if, twm_res_if) and topic_wildcard_matcher

module tb_topic_wildcard_matcher;
    import twm_pkg::*;

    // wildcard and separator bytes of the filter syntax
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_HASH  = 8'h23;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_A     = 8'h61;

    // watchdog: cycles in a row with no request and no result accepted
    localparam int STALL_LIMIT  = 3000;
    // long output stall that fills the result queue and backs up i_req
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        VD_RUNNING,
        VD_MATCHED,
        VD_FAILED
    } t_verdict;

    // mirrors the matcher: filter store, walk position, one-byte lookahead,
    // and the verdicts of finished topics still waiting on o_res
    class topic_match_scoreboard;
        t_char     filt_store [MAX_FILTER_LEN];
        int        filt_len;
        bit        loading;
        bit        filt_ovf;
        int        filt_pos;
        t_verdict  verdict;
        t_char     held_char;
        bit        held_valid;
        t_res_data verdicts_due [$];
        int        errors;

        function new();
            filt_len = 0;
            loading  = 1'b0;
            filt_ovf = 1'b0;
            errors   = 0;
            drop_topic();
        endfunction

        function void drop_topic();
            filt_pos   = 0;
            verdict    = VD_RUNNING;
            held_char  = '0;
            held_valid = 1'b0;
        endfunction

        // one topic byte against the filter byte at the current position
        function void match_char(t_char c, t_char nxt);
            t_char f;
            if (verdict == VD_RUNNING) begin
                if (filt_pos >= filt_len) begin
                    verdict = VD_FAILED;
                end else begin
                    f = filt_store[filt_pos];
                    if (f == CH_HASH) begin
                        verdict = VD_MATCHED;
                    end else if (f == c) begin
                        filt_pos++;
                    end else if (f == CH_PLUS) begin
                        if (nxt == CH_SLASH)
                            filt_pos++;
                    end else begin
                        verdict = VD_FAILED;
                    end
                end
            end
        endfunction

        // leftover filter only passes when it sits on a '+'
        function void close_topic();
            if (verdict == VD_RUNNING) begin
                if (filt_pos < filt_len && filt_store[filt_pos] != CH_PLUS)
                    verdict = VD_FAILED;
                else
                    verdict = VD_MATCHED;
            end
        endfunction

        function void note_request(logic op, t_char ch, logic is_last);
            t_res_data due;
            if (op == OP_LOAD) begin
                drop_topic();
                if (!loading) begin
                    filt_len = 0;
                    filt_ovf = 1'b0;
                end
                if (filt_len < MAX_FILTER_LEN) begin
                    filt_store[filt_len] = ch;
                    filt_len++;
                end else begin
                    filt_ovf = 1'b1;
                end
                loading = !is_last;
            end else begin
                loading = 1'b0;
                if (held_valid)
                    match_char(held_char, ch);
                if (!is_last) begin
                    held_char  = ch;
                    held_valid = 1'b1;
                end else begin
                    match_char(ch, '0);
                    close_topic();
                    due.matched         = (verdict == VD_MATCHED);
                    due.filter_overflow = filt_ovf;
                    verdicts_due.push_back(due);
                    drop_topic();
                end
            end
        endfunction

        function void check_result(t_res_data got);
            t_res_data due;
            if (verdicts_due.size() == 0) begin
                $error("result with no topic pending: matched %0b filter_overflow %0b",
                       got.matched, got.filter_overflow);
                errors++;
            end else begin
                due = verdicts_due.pop_front();
                if (got.matched !== due.matched) begin
                    $error("matched: expected %0b, actual %0b", due.matched, got.matched);
                    errors++;
                end
                if (got.filter_overflow !== due.filter_overflow) begin
                    $error("filter_overflow: expected %0b, actual %0b",
                           due.filter_overflow, got.filter_overflow);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    twm_req_if req_if();
    twm_res_if res_if();

    topic_match_scoreboard sb = new();

    // idle chances in percent, changed per phase by the stimulus process
    int tx_idle_pct = 31;
    int rx_idle_pct = 86;
    // requests accepted so far, drives the phase boundaries
    int sent_count = 0;
    // consecutive cycles without any handshake, watched by the watchdog
    int stall_cycles = 0;
    // set by the stimulus, taken and cleared by the receiver
    bit hold_req = 1'b0;

    // scratch strings built by the generators below
    t_char filter_chars [$];
    t_char topic_chars  [$];

    topic_wildcard_matcher dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitor: both channels sampled at the edge, before any drive lands
    always @(posedge clk) begin : mon
        t_res_data got;
        bit        moved;
        if (rst_n === 1'b1) begin
            moved = 1'b0;
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                sb.note_request(req_if.opcode, req_if.character, req_if.last);
                moved = 1'b1;
            end
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.matched         = res_if.matched;
                got.filter_overflow = res_if.filter_overflow;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (moved)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog: a hung block ends the run as a failure
    initial begin
        @(posedge clk);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random back-pressure, or one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // one request: random idle cycles first, then hold valid until taken;
    // valid stays high on return so back-to-back requests have no gap
    task automatic send_req(logic op, t_char ch, logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.character <= ch;
        req_if.last      <= is_last;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
    endtask

    // first n bytes of a string; the last one flagged only if asked
    task automatic send_chars(logic op, input t_char chars [$], int n, bit with_last);
        for (int i = 0; i < n; i++)
            send_req(op, chars[i], with_last && (i == n - 1));
    endtask

    task automatic send_text(logic op, string s);
        for (int i = 0; i < s.len(); i++)
            send_req(op, t_char'(s[i]), i == s.len() - 1);
    endtask

    // sender pause: nothing offered until every verdict has come back
    task automatic wait_verdicts();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // mostly a small alphabet so that topics hit the filter, now and then any byte
    function automatic t_char lit_char();
        if ($urandom_range(9) == 0)
            return t_char'($urandom_range(1, 255));
        return CH_A + t_char'($urandom_range(2));
    endfunction

    // well-formed filter: segments of literals or '+', maybe a trailing "/#", or rarely a lone '#'
    function automatic void make_filter();
        int nseg;
        nseg = $urandom_range(1, 4);
        filter_chars.delete();
        for (int s = 0; s < nseg; s++) begin
            if (s > 0)
                filter_chars.push_back(CH_SLASH);
            if ($urandom_range(9) < 3)
                filter_chars.push_back(CH_PLUS);
            else
                repeat ($urandom_range(1, 3)) filter_chars.push_back(lit_char());
        end
        if ($urandom_range(3) == 0) begin
            filter_chars.push_back(CH_SLASH);
            filter_chars.push_back(CH_HASH);
        end
        if ($urandom_range(19) == 0) begin
            filter_chars.delete();
            filter_chars.push_back(CH_HASH);
        end
    endfunction

    // around the store size, so some loads get truncated
    function automatic void make_long_filter();
        int n;
        n = $urandom_range(MAX_FILTER_LEN - 2, MAX_FILTER_LEN + 8);
        filter_chars.delete();
        repeat (n) begin
            case ($urandom_range(9))
                0:       filter_chars.push_back(CH_SLASH);
                1:       filter_chars.push_back(CH_PLUS);
                default: filter_chars.push_back(lit_char());
            endcase
        end
    endfunction

    // topic built to match the current filter, then sometimes broken
    function automatic void make_topic();
        bit done;
        int sz;
        done = 1'b0;
        topic_chars.delete();
        for (int k = 0; k < filter_chars.size() && !done; k++) begin
            if (filter_chars[k] == CH_PLUS) begin
                repeat ($urandom_range(1, 3))
                    topic_chars.push_back(CH_A + t_char'($urandom_range(2)));
            end else if (filter_chars[k] == CH_HASH) begin
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(2))
                        0:       topic_chars.push_back(CH_SLASH);
                        default: topic_chars.push_back(CH_A + t_char'($urandom_range(1)));
                    endcase
                end
                done = 1'b1;
            end else begin
                topic_chars.push_back(filter_chars[k]);
            end
        end
        sz = topic_chars.size();
        case ($urandom_range(11))
            0: if (sz > 0) topic_chars[$urandom_range(sz - 1)] = t_char'($urandom_range(1, 255));
            1: if (sz > 1) void'(topic_chars.pop_back());
            2: topic_chars.push_back(lit_char());
            default: ;
        endcase
        if (topic_chars.size() == 0)
            topic_chars.push_back(CH_A);
    endfunction

    // one filter load followed by a few topics against it
    task automatic random_round(bit force_long);
        int ntop;
        if (force_long || $urandom_range(99) < 4)
            make_long_filter();
        else
            make_filter();
        // now and then a topic breaks into an unfinished load
        if ($urandom_range(99) < 8)
            send_chars(OP_LOAD, filter_chars, $urandom_range(1, filter_chars.size()), 1'b0);
        else
            send_chars(OP_LOAD, filter_chars, filter_chars.size(), 1'b1);
        ntop = $urandom_range(1, 5);
        for (int t = 0; t < ntop; t++) begin
            if ($urandom_range(9) == 0) begin
                // noise topic of arbitrary bytes
                topic_chars.delete();
                repeat ($urandom_range(1, 5))
                    topic_chars.push_back(t_char'($urandom_range(1, 255)));
            end else begin
                make_topic();
            end
            // an unfinished topic gets dropped by the next round's load
            if (t == ntop - 1 && $urandom_range(99) < 6)
                send_chars(OP_TOPIC, topic_chars, $urandom_range(1, topic_chars.size()), 1'b0);
            else
                send_chars(OP_TOPIC, topic_chars, topic_chars.size(), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        req_if.valid     <= 1'b0;
        req_if.opcode    <= OP_LOAD;
        req_if.character <= CH_A;
        req_if.last      <= 1'b0;
        rst_n            <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty filter after reset fails every topic
        send_text(OP_TOPIC, "z");
        // '#' needs a topic byte to act on, so "x#" rejects "x" but takes "xy"
        send_text(OP_LOAD, "x#");
        send_text(OP_TOPIC, "x");
        send_text(OP_TOPIC, "xy");
        // '+' spans up to the slash; a topic ending on '+' matches despite leftovers
        send_text(OP_LOAD, "+/b");
        send_text(OP_TOPIC, "a/b");
        send_text(OP_TOPIC, "a");
        // topic during a load ends the load with what is stored
        send_req(OP_LOAD, CH_A, 1'b0);
        send_req(OP_TOPIC, CH_A, 1'b1);
        // load during a topic abandons it; extreme byte values
        send_req(OP_TOPIC, CH_A, 1'b0);
        send_req(OP_LOAD, 8'hFF, 1'b1);
        send_req(OP_TOPIC, 8'hFF, 1'b1);
        // topic byte that mismatches the one-byte filter
        send_req(OP_TOPIC, 8'h01, 1'b1);

        // phase 1: sender mostly busy, receiver mostly stalled; first filter is a long one near the store size
        random_round(1'b1);
        while (sent_count < 620)
            random_round(1'b0);
        wait_verdicts();

        // phase 2: roles swapped
        tx_idle_pct = 86;
        rx_idle_pct = 31;
        while (sent_count < 1170)
            random_round(1'b0);
        wait_verdicts();

        // phase 3: full rate, opened by one long output stall that backs up i_req
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        while (sent_count < 1720)
            random_round(1'b0);
        wait_verdicts();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/twm_pkg.sv
rtl/twm_if.sv
rtl/twm_filter_ram.sv
rtl/twm_matcher.sv
rtl/twm_result_q.sv
rtl/topic_wildcard_matcher.sv
rtl/twm_checker.sv
verif/tb_topic_wildcard_matcher.sv
